// ===== hw/rtl/vec4_pkg.sv =====
// vec4_pkg: shared constants, opcodes, pipeline context type and clamp helper
// for the vec4_alu block. No dependencies.
`default_nettype none
package vec4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_BITS       = 33;  // root bits of a 65-bit sum of squares

  localparam logic [3:0] OP_DOT   = 4'd0;
  localparam logic [3:0] OP_MAG   = 4'd1;
  localparam logic [3:0] OP_DIST  = 4'd2;
  localparam logic [3:0] OP_NORM  = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_SDIV  = 4'd8;
  localparam logic [3:0] OP_MAGCMP = 4'd9;
  localparam logic [3:0] OP_EQ    = 4'd10;

  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } clamp_t;

  // Per-item data that travels alongside the arithmetic pipeline
  typedef struct packed {
    logic [3:0]        op;
    word_t [3:0]       a;
    word_t [3:0]       b;
    word_t [3:0]       ew;
    logic [3:0]        ew_sat;
    word_t             dot;
    logic              dot_sat;
    logic              less;
    logic              eqm;
    logic              big;
    logic [SQ_BITS-1:0] root;
  } ctx_t;

  function automatic clamp_t clamp66(input logic signed [65:0] v);
    clamp_t c;
    if (v > 66'sd2147483647) begin
      c.val = WORD_MAX;
      c.sat = 1'b1;
    end else if (v < -66'sd2147483648) begin
      c.val = WORD_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = v[31:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vec4_in_if.sv =====
// vec4_in_if: input channel of vec4_alu, opcode plus vectors A and B.
// Uses no package.
`default_nettype none
interface vec4_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] a_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] b_w;

  modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vec4_out_if.sv =====
// vec4_out_if: result channel of vec4_alu, vector, scalar and flag fields.
// Uses no package.
`default_nettype none
interface vec4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_w;
  logic signed [31:0] scalar_out;
  logic               mag_less;
  logic               mag_equal;
  logic               vectors_equal;
  logic               saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, scalar_out, mag_less, mag_equal,
                  vectors_equal, saturated, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, scalar_out, mag_less, mag_equal,
                vectors_equal, saturated, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vec4_alu.sv =====
// vec4_alu: four-component Q-format vector ALU, top level.
// Throughput: one transfer per cycle; the whole pipeline advances together
// and holds while the output register keeps an untaken result.
// Depth is set by the 33-stage square root followed by the 32+FRAC_BITS
// stage divider. Reset (rst, synchronous) clears all valid bits only.
// Depends on vec4_pkg, vec4_in_if, vec4_out_if, vec4_lane, vec4_sqrt, vec4_div.
`default_nettype none
module vec4_alu #(
  parameter int FRAC_BITS = vec4_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vec4_in_if.sink    in_ch,
  vec4_out_if.source out_ch
);

  localparam int NW   = 32 + FRAC_BITS;
  localparam int K_RT = 5 + vec4_pkg::SQ_BITS;  // stage where the root appears
  localparam int KD   = K_RT + NW;              // stage where quotients appear
  localparam logic [65:0] RND = (66'd1 << FRAC_BITS) - 66'd1;

  logic en;
  logic out_v;
  logic [KD:1] vld;

  // Pipeline advances whenever the output register is free or being taken
  assign en          = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- lanes: stages 1..3 ----------------
  vec4_pkg::word_t    in_a [4];
  vec4_pkg::word_t    in_b [4];
  logic signed [63:0] l_prod [4];
  logic [63:0]        l_sqa [4];
  logic [63:0]        l_sqb [4];
  logic [3:0]         l_big;
  vec4_pkg::word_t    l_ew [4];
  logic [3:0]         l_ews;

  assign in_a[0] = in_ch.a_x;
  assign in_a[1] = in_ch.a_y;
  assign in_a[2] = in_ch.a_z;
  assign in_a[3] = in_ch.a_w;
  assign in_b[0] = in_ch.b_x;
  assign in_b[1] = in_ch.b_y;
  assign in_b[2] = in_ch.b_z;
  assign in_b[3] = in_ch.b_w;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    vec4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .op     (in_ch.opcode),
      .a      (in_a[i]),
      .b      (in_b[i]),
      .prod   (l_prod[i]),
      .sqa    (l_sqa[i]),
      .sqb    (l_sqb[i]),
      .big    (l_big[i]),
      .ew     (l_ew[i]),
      .ew_sat (l_ews[i])
    );
  end

  // ---------------- merge tree: stages 4 and 5 ----------------
  logic signed [64:0] dot4 [2];
  logic [64:0]        sa4 [2];
  logic [64:0]        sb4 [2];
  logic               big4, big5;
  logic signed [65:0] dot5;
  logic [64:0]        sa5, sb5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        dot4[j] <= 65'(l_prod[2*j]) + 65'(l_prod[2*j+1]);
        sa4[j]  <= {1'b0, l_sqa[2*j]} + {1'b0, l_sqa[2*j+1]};
        sb4[j]  <= {1'b0, l_sqb[2*j]} + {1'b0, l_sqb[2*j+1]};
      end
      big4 <= |l_big;
      dot5 <= 66'(dot4[0]) + 66'(dot4[1]);
      sa5  <= sa4[0] + sa4[1];
      sb5  <= sb4[0] + sb4[1];
      big5 <= big4;
    end
  end

  // dot product: truncate toward zero, then clamp
  logic signed [65:0] dot_t;
  vec4_pkg::clamp_t   dot_c;

  always_comb begin
    dot_t = (dot5 + (dot5[65] ? $signed(RND) : 66'sd0)) >>> FRAC_BITS;
    dot_c = vec4_pkg::clamp66(dot_t);
  end

  // ---------------- square root: stages 6..K_RT ----------------
  logic [vec4_pkg::SQ_BITS-1:0] root;

  vec4_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sa5),
    .root (root)
  );

  // ---------------- context line ----------------
  vec4_pkg::ctx_t ctx [1:KD];
  vec4_pkg::ctx_t ctx_in;

  always_comb begin
    ctx_in        = '0;
    ctx_in.op     = in_ch.opcode;
    for (int i = 0; i < 4; i++) begin
      ctx_in.a[i] = in_a[i];
      ctx_in.b[i] = in_b[i];
    end
  end

  // each stage takes its predecessor, with results merged in where they appear
  always_ff @(posedge clk) begin
    vec4_pkg::ctx_t nx;
    if (en) begin
      ctx[1] <= ctx_in;
      for (int k = 2; k <= KD; k++) begin
        nx = ctx[k-1];
        if (k == 4) begin
          for (int i = 0; i < 4; i++) nx.ew[i] = l_ew[i];
          nx.ew_sat = l_ews;
        end
        if (k == 6) begin
          nx.dot     = dot_c.val;
          nx.dot_sat = dot_c.sat;
          nx.less    = sa5 < sb5;
          nx.eqm     = sa5 == sb5;
          nx.big     = big5;
        end
        if (k == K_RT + 1) nx.root = root;
        ctx[k] <= nx;
      end
    end
  end

  // ---------------- dividers: stages K_RT+1..KD ----------------
  vec4_pkg::ctx_t  cr;
  logic [31:0]     d_num [4];
  logic [32:0]     d_den [4];
  logic [NW-1:0]   quo [4];

  assign cr = ctx[K_RT];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_num[i] = cr.a[i][31] ? 32'(-cr.a[i]) : 32'(cr.a[i]);
      if (cr.op == vec4_pkg::OP_NORM)
        d_den[i] = root;
      else if (cr.op == vec4_pkg::OP_DIV)
        d_den[i] = {1'b0, (cr.b[i][31] ? 32'(-cr.b[i]) : 32'(cr.b[i]))};
      else
        d_den[i] = {1'b0, 32'(cr.b[0])};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    vec4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (d_num[i]),
      .den (d_den[i]),
      .quo (quo[i])
    );
  end

  // ---------------- result select: output register ----------------
  vec4_pkg::ctx_t  fc;
  vec4_pkg::word_t fx_val [4];
  logic [3:0]      fx_sat;
  vec4_pkg::word_t r_n [4];
  logic [3:0]      rs_n;
  vec4_pkg::word_t scal_n;
  logic            ssat_n, less_n, eqm_n, eqv_n;
  logic            neg;

  assign fc = ctx[KD];

  // signed quotient with clamp; divide by zero handled per op below
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg = fc.a[i][31] ^ ((fc.op == vec4_pkg::OP_DIV) && fc.b[i][31]);
      if (neg) begin
        if (quo[i] > NW'(33'h0_8000_0000)) begin
          fx_val[i] = vec4_pkg::WORD_MIN;
          fx_sat[i] = 1'b1;
        end else begin
          fx_val[i] = 32'(-quo[i][31:0]);
          fx_sat[i] = 1'b0;
        end
      end else begin
        if (quo[i] > NW'(32'h7FFF_FFFF)) begin
          fx_val[i] = vec4_pkg::WORD_MAX;
          fx_sat[i] = 1'b1;
        end else begin
          fx_val[i] = quo[i][31:0];
          fx_sat[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) r_n[i] = '0;
    rs_n   = '0;
    scal_n = '0;
    ssat_n = 1'b0;
    less_n = 1'b0;
    eqm_n  = 1'b0;
    eqv_n  = 1'b0;
    unique case (fc.op)
      vec4_pkg::OP_DOT: begin
        scal_n = fc.dot;
        ssat_n = fc.dot_sat;
      end
      vec4_pkg::OP_MAG, vec4_pkg::OP_DIST: begin
        if (fc.big || fc.root > 33'h0_7FFF_FFFF) begin
          scal_n = vec4_pkg::WORD_MAX;
          ssat_n = 1'b1;
        end else begin
          scal_n = fc.root[31:0];
        end
      end
      vec4_pkg::OP_NORM: begin
        if (fc.root != '0) begin
          for (int i = 0; i < 4; i++) r_n[i] = fx_val[i];
          rs_n = fx_sat;
        end
      end
      vec4_pkg::OP_ADD, vec4_pkg::OP_SUB, vec4_pkg::OP_MUL: begin
        for (int i = 0; i < 4; i++) r_n[i] = fc.ew[i];
        rs_n = fc.ew_sat;
      end
      vec4_pkg::OP_DIV: begin
        if (fc.b != '0) begin
          for (int i = 0; i < 4; i++) begin
            if (fc.b[i] != '0) begin
              r_n[i]  = fx_val[i];
              rs_n[i] = fx_sat[i];
            end else if (fc.a[i] != '0) begin
              // zero divisor: saturate by the sign of the dividend
              r_n[i]  = fc.a[i][31] ? vec4_pkg::WORD_MIN : vec4_pkg::WORD_MAX;
              rs_n[i] = 1'b1;
            end
          end
        end
      end
      vec4_pkg::OP_SDIV: begin
        if (!fc.b[0][31] && fc.b[0] != '0) begin
          for (int i = 0; i < 4; i++) r_n[i] = fx_val[i];
          rs_n = fx_sat;
        end
      end
      vec4_pkg::OP_MAGCMP: begin
        less_n = fc.less;
        eqm_n  = fc.eqm;
      end
      vec4_pkg::OP_EQ: begin
        eqv_n = fc.a == fc.b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      vld   <= {vld[KD-1:1], in_ch.valid};
      out_v <= vld[KD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.r_x           <= r_n[0];
      out_ch.r_y           <= r_n[1];
      out_ch.r_z           <= r_n[2];
      out_ch.r_w           <= r_n[3];
      out_ch.scalar_out    <= scal_n;
      out_ch.mag_less      <= less_n;
      out_ch.mag_equal     <= eqm_n;
      out_ch.vectors_equal <= eqv_n;
      out_ch.saturated     <= ssat_n || (|rs_n);
    end
  end

  assign out_ch.valid = out_v;

  // ---------------- assertions ----------------
  // a stalled pipeline keeps its items
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(out_v))
    else $error("pipeline moved while stalled");

  // magnitude compare cannot be both less and equal
  a_cmp_excl: assert property (@(posedge clk) disable iff (rst)
    out_v |-> !(out_ch.mag_less && out_ch.mag_equal))
    else $error("mag_less and mag_equal both set");

  // comparison results carry no scalar result, no x component and no saturation
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_v && (out_ch.mag_less || out_ch.mag_equal || out_ch.vectors_equal) |->
      out_ch.scalar_out == '0 && out_ch.r_x == '0 && !out_ch.saturated)
    else $error("flag result mixed with numeric result");

  // a scalar result never comes with a vector result
  a_scal_novec: assert property (@(posedge clk) disable iff (rst)
    out_v && out_ch.scalar_out != '0 |->
      out_ch.r_x == '0 && out_ch.r_y == '0 && out_ch.r_z == '0 && out_ch.r_w == '0)
    else $error("scalar and vector result both nonzero");

endmodule
`default_nettype wire

// ===== hw/rtl/vec4_lane.sv =====
// vec4_lane: one component lane, 3 stages: input register, multipliers,
// elementwise result. Depends on vec4_pkg.
`default_nettype none
module vec4_lane #(
  parameter int FRAC_BITS = vec4_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [3:0]          op,
  input  vec4_pkg::word_t     a,
  input  vec4_pkg::word_t     b,
  output logic signed [63:0]  prod,
  output logic [63:0]         sqa,
  output logic [63:0]         sqb,
  output logic                big,
  output vec4_pkg::word_t     ew,
  output logic                ew_sat
);

  localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

  // stage 1
  logic [3:0]          op1;
  vec4_pkg::word_t     a1, b1;
  // stage 2
  logic [3:0]          op2;
  logic signed [63:0]  prod2;
  logic [63:0]         sqa2, sqb2;
  logic                big2;
  vec4_pkg::word_t     ew2;
  logic                ews2;

  logic signed [32:0]  diff, sum, addsub;
  logic [32:0]         mag;
  logic                big1;
  logic [31:0]         msel, mb;
  vec4_pkg::clamp_t    as_c, mul_c;
  logic signed [63:0]  mul_t;

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op;
      a1  <= a;
      b1  <= b;
    end
  end

  always_comb begin
    diff   = 33'(a1) - 33'(b1);
    sum    = 33'(a1) + 33'(b1);
    mag    = (op1 == vec4_pkg::OP_DIST) ? (diff[32] ? 33'(-diff) : 33'(diff))
                                        : (a1[31] ? 33'(-33'(a1)) : 33'(a1));
    big1   = mag > 33'h0_8000_0000;
    msel   = big1 ? 32'd0 : mag[31:0];
    mb     = b1[31] ? 32'(-b1) : 32'(b1);
    addsub = (op1 == vec4_pkg::OP_ADD) ? sum : diff;
    as_c   = vec4_pkg::clamp66(66'(addsub));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      prod2 <= a1 * b1;
      sqa2  <= msel * msel;
      sqb2  <= mb * mb;
      big2  <= big1;
      ew2   <= as_c.val;
      ews2  <= as_c.sat;
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    mul_t = (prod2 + (prod2[63] ? $signed(RND) : 64'sd0)) >>> FRAC_BITS;
    mul_c = vec4_pkg::clamp66(66'(mul_t));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod2;
      sqa  <= sqa2;
      sqb  <= sqb2;
      big  <= big2;
      if (op2 == vec4_pkg::OP_MUL) begin
        ew     <= mul_c.val;
        ew_sat <= mul_c.sat;
      end else begin
        ew     <= ew2;
        ew_sat <= ews2;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vec4_sqrt.sv =====
// vec4_sqrt: pipelined floor square root of a 65-bit value, one root bit
// per stage. Depends on vec4_pkg.
`default_nettype none
module vec4_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [64:0]                   rad,
  output logic [vec4_pkg::SQ_BITS-1:0]  root
);

  localparam int N = vec4_pkg::SQ_BITS;

  logic [2*N-1:0] xs [N+1];
  logic [N:0]     rs [N+1];
  logic [N-1:0]   qs [N+1];

  assign xs[0] = {1'b0, rad};
  assign rs[0] = '0;
  assign qs[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N+2:0]   rem_sh, trial;
    logic [2*N-1:0] x_q;
    logic [N:0]     r_q;
    logic [N-1:0]   q_q;

    assign rem_sh = {rs[i], xs[i][2*N-1:2*N-2]};
    assign trial  = {1'b0, qs[i], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        x_q <= {xs[i][2*N-3:0], 2'b00};
        if (rem_sh >= trial) begin
          r_q <= (N+1)'(rem_sh - trial);
          q_q <= {qs[i][N-2:0], 1'b1};
        end else begin
          r_q <= rem_sh[N:0];
          q_q <= {qs[i][N-2:0], 1'b0};
        end
      end
    end

    assign xs[i+1] = x_q;
    assign rs[i+1] = r_q;
    assign qs[i+1] = q_q;
  end

  assign root = qs[N];

endmodule
`default_nettype wire

// ===== hw/rtl/vec4_div.sv =====
// vec4_div: pipelined restoring divider, (num << FRAC_BITS) / den, unsigned,
// one quotient bit per stage. Depends on vec4_pkg.
`default_nettype none
module vec4_div #(
  parameter int FRAC_BITS = vec4_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [31:0]           num,
  input  logic [32:0]           den,
  output logic [32+FRAC_BITS-1:0] quo
);

  localparam int NW = 32 + FRAC_BITS;

  logic [NW-1:0] ns [NW+1];
  logic [32:0]   rs [NW+1];
  logic [32:0]   ds [NW+1];
  logic [NW-1:0] qs [NW+1];

  assign ns[0] = {num, {FRAC_BITS{1'b0}}};
  assign rs[0] = '0;
  assign ds[0] = den;
  assign qs[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [33:0]   sh;
    logic [NW-1:0] n_q, q_q;
    logic [32:0]   r_q, d_q;

    assign sh = {rs[i], ns[i][NW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= {ns[i][NW-2:0], 1'b0};
        d_q <= ds[i];
        if (sh >= {1'b0, ds[i]}) begin
          r_q <= 33'(sh - {1'b0, ds[i]});
          q_q <= {qs[i][NW-2:0], 1'b1};
        end else begin
          r_q <= sh[32:0];
          q_q <= {qs[i][NW-2:0], 1'b0};
        end
      end
    end

    assign ns[i+1] = n_q;
    assign rs[i+1] = r_q;
    assign ds[i+1] = d_q;
    assign qs[i+1] = q_q;
  end

  assign quo = qs[NW];

endmodule
`default_nettype wire

// ===== sim/vec4_checker.sv =====
// vec4_checker: watches both channels of vec4_alu, predicts each result and
// compares it field by field. Depends on vec4_pkg, vec4_in_if, vec4_out_if.
`default_nettype none
module vec4_checker (
  input  logic clk,
  input  logic rst,
  vec4_in_if   in_ch,
  vec4_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [3:0]      op;
    vec4_pkg::word_t rx;
    vec4_pkg::word_t ry;
    vec4_pkg::word_t rz;
    vec4_pkg::word_t rw;
    vec4_pkg::word_t scal;
    logic            less;
    logic            eqm;
    logic            eqv;
    logic            sat;
  } alu_result_t;

  localparam wide_t FRAC_ONE = 128'sd65536;

  alu_result_t result_fifo[$];

  function automatic logic [127:0] floor_root(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic vec4_pkg::word_t clamp_word(input wide_t v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return vec4_pkg::WORD_MAX;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return vec4_pkg::WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic alu_result_t compute_result(input logic [3:0] op,
                                                 input wide_t va[4],
                                                 input wide_t vb[4]);
    alu_result_t res;
    wide_t       r[4];
    wide_t       acc;
    wide_t       accb;
    wide_t       d;
    wide_t       g;
    logic        vec;
    logic        sat;
    logic        any_b;
    res = '0;
    res.op = op;
    vec = 1'b0;
    sat = 1'b0;
    acc = '0;
    accb = '0;
    for (int i = 0; i < 4; i++) r[i] = '0;
    case (op)
      vec4_pkg::OP_DOT: begin
        for (int i = 0; i < 4; i++) acc += va[i] * vb[i];
        res.scal = clamp_word(acc / FRAC_ONE, sat);
      end
      vec4_pkg::OP_MAG, vec4_pkg::OP_DIST: begin
        for (int i = 0; i < 4; i++) begin
          d = (op == vec4_pkg::OP_DIST) ? va[i] - vb[i] : va[i];
          acc += d * d;
        end
        res.scal = clamp_word($signed(floor_root(acc)), sat);
      end
      vec4_pkg::OP_NORM: begin
        vec = 1'b1;
        for (int i = 0; i < 4; i++) acc += va[i] * va[i];
        g = $signed(floor_root(acc));
        if (g > 0)
          for (int i = 0; i < 4; i++) r[i] = (va[i] * FRAC_ONE) / g;
      end
      vec4_pkg::OP_ADD, vec4_pkg::OP_SUB, vec4_pkg::OP_MUL: begin
        vec = 1'b1;
        for (int i = 0; i < 4; i++)
          if (op == vec4_pkg::OP_ADD) r[i] = va[i] + vb[i];
          else if (op == vec4_pkg::OP_SUB) r[i] = va[i] - vb[i];
          else r[i] = (va[i] * vb[i]) / FRAC_ONE;
      end
      vec4_pkg::OP_DIV: begin
        vec = 1'b1;
        any_b = 1'b0;
        for (int i = 0; i < 4; i++) if (vb[i] != 0) any_b = 1'b1;
        // all-zero divisor gives zero; a zero lane saturates by sign of nonzero A
        if (any_b)
          for (int i = 0; i < 4; i++)
            if (vb[i] != 0) r[i] = (va[i] * FRAC_ONE) / vb[i];
            else if (va[i] > 0) r[i] = 128'sd2147483648;
            else if (va[i] < 0) r[i] = -128'sd2147483649;
      end
      vec4_pkg::OP_SDIV: begin
        vec = 1'b1;
        if (vb[0] > 0)
          for (int i = 0; i < 4; i++) r[i] = (va[i] * FRAC_ONE) / vb[0];
      end
      vec4_pkg::OP_MAGCMP: begin
        for (int i = 0; i < 4; i++) begin
          acc += va[i] * va[i];
          accb += vb[i] * vb[i];
        end
        res.less = acc < accb;
        res.eqm = acc == accb;
      end
      vec4_pkg::OP_EQ: res.eqv = (va[0] == vb[0]) && (va[1] == vb[1]) &&
                                 (va[2] == vb[2]) && (va[3] == vb[3]);
      default: ;
    endcase
    if (vec) begin
      res.rx = clamp_word(r[0], sat);
      res.ry = clamp_word(r[1], sat);
      res.rz = clamp_word(r[2], sat);
      res.rw = clamp_word(r[3], sat);
    end
    res.sat = sat;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    wide_t       va[4];
    wide_t       vb[4];
    alu_result_t got;
    alu_result_t exp_res;
    if (!rst && in_ch.valid && in_ch.ready) begin
      va[0] = $signed(in_ch.a_x); va[1] = $signed(in_ch.a_y);
      va[2] = $signed(in_ch.a_z); va[3] = $signed(in_ch.a_w);
      vb[0] = $signed(in_ch.b_x); vb[1] = $signed(in_ch.b_y);
      vb[2] = $signed(in_ch.b_z); vb[3] = $signed(in_ch.b_w);
      result_fifo.push_back(compute_result(in_ch.opcode, va, vb));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '0;
      got.rx = out_ch.r_x; got.ry = out_ch.r_y;
      got.rz = out_ch.r_z; got.rw = out_ch.r_w;
      got.scal = out_ch.scalar_out;
      got.less = out_ch.mag_less; got.eqm = out_ch.mag_equal;
      got.eqv = out_ch.vectors_equal; got.sat = out_ch.saturated;
      checked++;
      if (result_fifo.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("ERROR: result transfer with nothing expected");
      end else begin
        exp_res = result_fifo.pop_front();
        got.op = exp_res.op;
        if (got !== exp_res) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR op %0d: exp r=%h %h %h %h s=%h l%b e%b v%b sat%b",
                     exp_res.op, exp_res.rx, exp_res.ry, exp_res.rz, exp_res.rw,
                     exp_res.scal, exp_res.less, exp_res.eqm, exp_res.eqv, exp_res.sat);
            $display("             got r=%h %h %h %h s=%h l%b e%b v%b sat%b",
                     got.rx, got.ry, got.rz, got.rw, got.scal,
                     got.less, got.eqm, got.eqv, got.sat);
          end
        end
      end
    end
    pending <= result_fifo.size();
  end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: drives vec4_alu with directed and random vector pairs under
// varied backpressure. Depends on vec4_pkg, both channel interfaces, vec4_checker.
`default_nettype none
module testbench;

  // opcodes above OP_EQ are unused and must give all-zero results
  localparam logic [3:0]      OP_SPARE = 4'd15;
  localparam vec4_pkg::word_t ONE_Q    = 32'sh0001_0000;
  localparam int              DRAIN    = 300;  // well past the pipeline depth

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle;
  int   recv_idle;
  int   fail_count;
  int   pending;
  int   checked;
  int   op_hits[16];

  vec4_in_if  in_ch ();
  vec4_out_if out_ch ();

  vec4_alu uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  vec4_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #4 clk = ~clk;

  // result side: stall at the current idle rate, one decision per cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // One transfer: optional idle cycles, then hold valid until accepted.
  task automatic send(input logic [3:0] op,
                      input vec4_pkg::word_t ax, ay, az, aw,
                      input vec4_pkg::word_t bx, by, bz, bw);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_x <= ax; in_ch.a_y <= ay; in_ch.a_z <= az; in_ch.a_w <= aw;
    in_ch.b_x <= bx; in_ch.b_y <= by; in_ch.b_z <= bz; in_ch.b_w <= bw;
    // ready is sampled at the edge itself, before this edge's updates land
    @(posedge clk iff in_ch.ready);
    op_hits[op]++;
  endtask

  // Operand mix: full range, small Q16.16 values, and the edge values.
  function automatic vec4_pkg::word_t pick_word();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4:    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      5:       return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      6:       return '0;
      7:       return $urandom_range(1) ? vec4_pkg::WORD_MAX : vec4_pkg::WORD_MIN;
      8:       return $urandom_range(1) ? ONE_Q : -ONE_Q;
      default: return $urandom_range(1) ? 32'sd1 : -32'sd1;
    endcase
  endfunction

  task automatic send_random();
    logic [3:0]      op;
    vec4_pkg::word_t v[8];
    op = $urandom_range(15);
    for (int i = 0; i < 8; i++) v[i] = pick_word();
    // equal and mirrored pairs so eq and magcmp see both outcomes
    if ((op == vec4_pkg::OP_EQ || op == vec4_pkg::OP_MAGCMP) && $urandom_range(1))
      for (int i = 0; i < 4; i++) v[4 + i] = (op == vec4_pkg::OP_EQ) ? v[i] : -v[i];
    send(op, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int covered;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w} = '0;
    out_ch.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 16; i++) op_hits[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each opcode at the field extremes and its special cases
    send(vec4_pkg::OP_DOT, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX,
         vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX,
         vec4_pkg::WORD_MAX);                                  // dot saturates high
    send(vec4_pkg::OP_DOT, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX,
         vec4_pkg::WORD_MAX);                                  // dot saturates low
    send(vec4_pkg::OP_DOT, ONE_Q, 0, 0, ONE_Q, ONE_Q, 0, 0, -ONE_Q); // w lane is a product
    send(vec4_pkg::OP_MAG, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN, 0, 0, 0, 0);
    send(vec4_pkg::OP_MAG, 3 * ONE_Q, 4 * ONE_Q, 0, 0, 0, 0, 0, 0);
    send(vec4_pkg::OP_DIST, vec4_pkg::WORD_MAX, 0, 0, 0,
         vec4_pkg::WORD_MIN, 0, 0, 0);                         // difference past 2^31
    send(vec4_pkg::OP_DIST, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0);
    send(vec4_pkg::OP_NORM, 0, 0, 0, 0, ONE_Q, 0, 0, 0);       // zero vector
    send(vec4_pkg::OP_NORM, 0, 0, 0, 32'sd1, 0, 0, 0, 0);      // tiny magnitude gives a unit result
    send(vec4_pkg::OP_NORM, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN, 0, 0, 0, 0);
    send(vec4_pkg::OP_ADD, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MIN, 1, -1, 1, -1, 1, -1);
    send(vec4_pkg::OP_SUB, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, 0, 0, 1, -1, 0, 0);
    send(vec4_pkg::OP_MUL, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, -ONE_Q, 32'sd3,
         vec4_pkg::WORD_MIN, 2, ONE_Q, -32'sd1);
    send(vec4_pkg::OP_DIV, ONE_Q, -ONE_Q, 0, 5, 0, 0, 0, 0);   // all-zero divisor
    send(vec4_pkg::OP_DIV, ONE_Q, -ONE_Q, 0, vec4_pkg::WORD_MIN,
         0, 0, 0, -32'sd1);                                    // zero lanes by sign
    send(vec4_pkg::OP_SDIV, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0);  // divisor zero
    send(vec4_pkg::OP_SDIV, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
         -ONE_Q, 0, 0, 0);                                     // divisor negative
    send(vec4_pkg::OP_SDIV, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MIN, -ONE_Q, 7,
         32'sd1, 0, 0, 0);
    send(vec4_pkg::OP_MAGCMP, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN);                                  // equal at full sum
    send(vec4_pkg::OP_MAGCMP, ONE_Q, 0, 0, 0, 0, -ONE_Q, 0, 0);
    send(vec4_pkg::OP_MAGCMP, 0, 0, 0, 0, 1, 0, 0, 0);
    send(vec4_pkg::OP_EQ, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, 0, 1,
         vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, 0, 1);
    send(vec4_pkg::OP_EQ, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, 0, 1,
         vec4_pkg::WORD_MIN, vec4_pkg::WORD_MAX, 0, 0);
    send(OP_SPARE, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX, vec4_pkg::WORD_MAX,
         vec4_pkg::WORD_MAX, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN, vec4_pkg::WORD_MIN,
         vec4_pkg::WORD_MIN);

    // random phases: sender mostly busy with slow receiver, then the reverse,
    // then no idling at all
    send_idle = 11; recv_idle = 84;
    for (int n = 0; n < 160; n++) send_random();
    wait_drained();  // let everything land before the next phase
    send_idle = 84; recv_idle = 11;
    for (int n = 0; n < 160; n++) send_random();
    send_idle = 0; recv_idle = 0;
    for (int n = 0; n < 160; n++) send_random();
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    covered = 0;
    for (int i = 0; i < 16; i++) if (op_hits[i] != 0) covered++;
    $display("Run summary: %0d results checked, %0d of 16 opcodes exercised,", checked, covered);
    $display("  under three sender/receiver stall profiles.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/vec4_pkg.sv
hw/rtl/vec4_in_if.sv
hw/rtl/vec4_out_if.sv
hw/rtl/vec4_lane.sv
hw/rtl/vec4_sqrt.sv
hw/rtl/vec4_div.sv
hw/rtl/vec4_alu.sv
sim/vec4_checker.sv
sim/testbench.sv
